@@ design/polar_grid_index_mapper_assert.svh @@
// Assertion helpers shared by the polar grid mapper RTL.
// Each macro expects clk and rst_n in scope.
`ifndef POLAR_GRID_INDEX_MAPPER_ASSERT_SVH
`define POLAR_GRID_INDEX_MAPPER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PGIM_ASSERT_IMPLY(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("pgim: implication check failed");

// Condition holds at every clock edge out of reset.
`define PGIM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pgim: invariant check failed");

`endif

@@ design/pgim_pkg.sv @@
// ----------------------------------------------------------------------------
// pgim_pkg
// Shared types, widths and helpers of the polar grid index mapper.
// ----------------------------------------------------------------------------
package pgim_pkg;

    localparam int FRAC_BITS  = 24;   // fraction bits of angle and log
    localparam int VEC_BITS   = 30;   // vector magnitudes stay below 2^30
    localparam int WIDE_BITS  = 61;   // squared vector before normalizing
    localparam int EXP_W      = 6;    // exponent of r^2, at most 63
    localparam int MANT_W     = 32;   // Q1.31 mantissa
    localparam int LOG_W      = EXP_W + FRAC_BITS;
    localparam int DIFF_W     = LOG_W + 1;
    localparam int N_W        = 59;
    localparam int BIN_W      = N_W - 1 - 41;
    localparam int BIN_SHIFT  = 41;
    localparam int OUT_BIN_W  = 10;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam logic [FRAC_BITS-1:0] THETA_HALF = 24'h800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_R_MIN_SQ      = 3'd0,
        REG_LOG2_R_MIN    = 3'd1,
        REG_LOG_SCALE     = 3'd2,
        REG_RADIAL_OFFSET = 3'd3,
        REG_N_RADIAL      = 3'd4,
        REG_N_ANGLE       = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [39:0] r_min_sq;
        logic [20:0] log2_r_min;
        logic [25:0] log_scale;
        logic [16:0] radial_offset;
        logic [CNT_W-1:0] n_radial;
        logic [CNT_W-1:0] n_angle;
    } cfg_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0]       th;
        logic signed [VEC_BITS:0]   vx;
        logic [VEC_BITS-1:0]        vy;
        logic [MANT_W-1:0]          mant;
        logic [FRAC_BITS-1:0]       frac;
        logic [EXP_W-1:0]           expo;
        logic                       gt;
        logic                       origin;
    } iter_t;

    typedef struct packed {
        logic [VEC_BITS-1:0] mx;
        logic [VEC_BITS-1:0] my;
    } vec_t;

    // Shift both magnitudes right, truncating, until both are below 2^30.
    function automatic vec_t vec_norm(input logic [WIDE_BITS-1:0] ax,
                                      input logic [WIDE_BITS-1:0] ay);
        logic [WIDE_BITS-1:0] both;
        logic [WIDE_BITS-1:0] sx;
        logic [WIDE_BITS-1:0] sy;
        logic [4:0]           s;
        vec_t                 r;
        both = ax | ay;
        s = '0;
        for (int i = 0; i < WIDE_BITS - VEC_BITS; i++)
        begin
            if (both[VEC_BITS+i])
            begin
                s = 5'(i + 1);
            end
        end
        sx = ax >> s;
        sy = ay >> s;
        r.mx = sx[VEC_BITS-1:0];
        r.my = sy[VEC_BITS-1:0];
        return r;
    endfunction

endpackage

@@ design/pgim_ifs.sv @@
// ----------------------------------------------------------------------------
// pgim channel interfaces
// Pixel input, bin result and register write channels.
// ----------------------------------------------------------------------------
interface pgim_pix_if #(parameter int COORD_BITS = 20);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface pgim_res_if;
    logic                                valid;
    logic                                ready;
    logic [pgim_pkg::OUT_BIN_W-1:0]      radial_bin;
    logic [pgim_pkg::OUT_BIN_W-1:0]      angle_bin;
    logic                                inside_res;
    modport source (output valid, output radial_bin, output angle_bin,
                    output inside_res, input ready);
    modport sink   (input valid, input radial_bin, input angle_bin,
                    input inside_res, output ready);
endinterface

interface pgim_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pgim_pkg::CFG_IDX_W-1:0]    index;
    logic [pgim_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/pgim_front.sv @@
// ----------------------------------------------------------------------------
// pgim_front
// Magnitudes, r^2, inner radius test, vector and mantissa normalization.
// ----------------------------------------------------------------------------
module pgim_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    pgim_pix_if.sink                pix,
    input  logic [39:0]             r_min_sq,
    output logic                    out_valid,
    output pgim_pkg::iter_t         out_data,
    input  logic                    out_ready
);
    localparam int RSQ_W = 2 * COORD_BITS;
    localparam int GT_W  = (RSQ_W > 40) ? RSQ_W : 40;

    // stage 1
    logic                  v1_reg;
    logic [COORD_BITS-1:0] ax1_reg, ay1_reg;
    logic                  xneg1_reg;
    logic [RSQ_W-1:0]      sqx1_reg, sqy1_reg;
    // stage 2
    logic                  v2_reg;
    logic [RSQ_W-1:0]      rsq2_reg;
    logic                  gt2_reg, origin2_reg;
    logic signed [pgim_pkg::VEC_BITS:0] vx2_reg;
    logic [pgim_pkg::VEC_BITS-1:0]      vy2_reg;
    // stage 3
    logic                  v3_reg;
    pgim_pkg::iter_t       d3_reg;

    logic rdy1, rdy2, rdy3;
    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pix.ready = rdy1;

    logic [COORD_BITS-1:0] px, py, ax, ay;
    logic                  xneg, yneg;
    always_comb
    begin
        px   = pix.pos_x;
        py   = pix.pos_y;
        xneg = px[COORD_BITS-1];
        yneg = py[COORD_BITS-1];
        ax   = xneg ? (~px + COORD_BITS'(1)) : px;
        ay   = yneg ? (~py + COORD_BITS'(1)) : py;
    end

    logic [RSQ_W-1:0]        rsq;
    pgim_pkg::vec_t          vn;
    logic [pgim_pkg::VEC_BITS:0] mxs;
    always_comb
    begin
        rsq = sqx1_reg + sqy1_reg;
        vn  = pgim_pkg::vec_norm(pgim_pkg::WIDE_BITS'(ax1_reg),
                                 pgim_pkg::WIDE_BITS'(ay1_reg));
        mxs = {1'b0, vn.mx};
    end

    logic [pgim_pkg::EXP_W-1:0]  e3;
    logic [RSQ_W+30:0]           ext3;
    always_comb
    begin
        e3 = '0;
        for (int i = 0; i < RSQ_W; i++)
        begin
            if (rsq2_reg[i])
            begin
                e3 = pgim_pkg::EXP_W'(i);
            end
        end
        ext3 = {rsq2_reg, 31'b0} >> e3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= pix.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pix.valid)
        begin
            ax1_reg   <= ax;
            ay1_reg   <= ay;
            xneg1_reg <= xneg;
            sqx1_reg  <= RSQ_W'(ax) * RSQ_W'(ax);
            sqy1_reg  <= RSQ_W'(ay) * RSQ_W'(ay);
        end
        if (rdy2 && v1_reg)
        begin
            rsq2_reg    <= rsq;
            gt2_reg     <= GT_W'(rsq) > GT_W'(r_min_sq);
            origin2_reg <= (ax1_reg == '0) && (ay1_reg == '0);
            vx2_reg     <= xneg1_reg ? -$signed(mxs) : $signed(mxs);
            vy2_reg     <= vn.my;
        end
        if (rdy3 && v2_reg)
        begin
            d3_reg.th     <= '0;
            d3_reg.vx     <= vx2_reg;
            d3_reg.vy     <= vy2_reg;
            d3_reg.mant   <= ext3[pgim_pkg::MANT_W-1:0];
            d3_reg.frac   <= '0;
            d3_reg.expo   <= e3;
            d3_reg.gt     <= gt2_reg;
            d3_reg.origin <= origin2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;
endmodule

@@ design/pgim_step.sv @@
// ----------------------------------------------------------------------------
// pgim_step
// One angle doubling step and one log squaring step, one register stage.
// ----------------------------------------------------------------------------
module pgim_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  pgim_pkg::iter_t  in_data,
    output logic             in_ready,
    output logic             out_valid,
    output pgim_pkg::iter_t  out_data,
    input  logic             out_ready
);
    logic            v_reg;
    pgim_pkg::iter_t d_reg;

    assign in_ready = !v_reg || out_ready;

    logic                                abit, lbit;
    logic [pgim_pkg::VEC_BITS-1:0]       xr, yr;
    logic signed [pgim_pkg::VEC_BITS:0]  negx;
    logic [59:0]                         sx, sy, pxy;
    logic signed [pgim_pkg::WIDE_BITS-1:0] nx;
    logic [pgim_pkg::WIDE_BITS-1:0]      nxa, ny;
    pgim_pkg::vec_t                      vn;
    logic [pgim_pkg::VEC_BITS:0]         mxs;
    logic [63:0]                         p;
    logic [32:0]                         ps;
    logic [pgim_pkg::MANT_W-1:0]         mant_n;

    always_comb
    begin
        // rotate by -pi/2 when x <= 0, leaving x >= 0 and y >= 0
        abit = in_data.vx[pgim_pkg::VEC_BITS] || (in_data.vx == '0);
        negx = -in_data.vx;
        xr   = abit ? in_data.vy : in_data.vx[pgim_pkg::VEC_BITS-1:0];
        yr   = abit ? negx[pgim_pkg::VEC_BITS-1:0] : in_data.vy;
        sx   = 60'(xr) * 60'(xr);
        sy   = 60'(yr) * 60'(yr);
        pxy  = 60'(xr) * 60'(yr);
        nx   = $signed({1'b0, sx}) - $signed({1'b0, sy});
        nxa  = nx[pgim_pkg::WIDE_BITS-1] ? pgim_pkg::WIDE_BITS'(-nx) : nx;
        ny   = {pxy, 1'b0};
        vn   = pgim_pkg::vec_norm(nxa, ny);
        mxs  = {1'b0, vn.mx};
        // square the mantissa; a carry into 2.0 is the next log bit
        p      = 64'(in_data.mant) * 64'(in_data.mant);
        ps     = p[63:31];
        lbit   = ps[32];
        mant_n = lbit ? ps[32:1] : ps[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg.th     <= {in_data.th[pgim_pkg::FRAC_BITS-2:0], abit};
            d_reg.vx     <= nx[pgim_pkg::WIDE_BITS-1] ? -$signed(mxs) : $signed(mxs);
            d_reg.vy     <= vn.my;
            d_reg.mant   <= mant_n;
            d_reg.frac   <= {in_data.frac[pgim_pkg::FRAC_BITS-2:0], lbit};
            d_reg.expo   <= in_data.expo;
            d_reg.gt     <= in_data.gt;
            d_reg.origin <= in_data.origin;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;
endmodule

@@ design/pgim_back.sv @@
// ----------------------------------------------------------------------------
// pgim_back
// Angle bin, radial scaling and range checks, output register.
// ----------------------------------------------------------------------------
module pgim_back #(
    parameter int RADIAL_BINS_MAX = 1024,
    parameter int ANGLE_BINS_MAX  = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  pgim_pkg::iter_t  in_data,
    output logic             in_ready,
    input  pgim_pkg::cfg_t   cfg,
    pgim_res_if.source       res
);
    logic                                  v1_reg, v2_reg, v3_reg;
    logic [pgim_pkg::OUT_BIN_W-1:0]        abin1_reg, abin2_reg, abin3_reg;
    logic signed [pgim_pkg::DIFF_W-1:0]    diff1_reg;
    logic                                  gt1_reg, gt2_reg;
    logic signed [pgim_pkg::N_W-1:0]       n2_reg;
    logic [pgim_pkg::OUT_BIN_W-1:0]        rbin3_reg;
    logic                                  inside3_reg;

    logic rdy1, rdy2, rdy3;
    assign rdy3     = !v3_reg || res.ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    logic [pgim_pkg::FRAC_BITS-1:0]  theta;
    logic [pgim_pkg::CNT_W-1:0]      na, nr;
    logic [34:0]                     aprod;
    logic [pgim_pkg::LOG_W-1:0]      alog;
    logic signed [pgim_pkg::DIFF_W-1:0] diff;
    logic signed [pgim_pkg::N_W-1:0] nval;
    logic [pgim_pkg::BIN_W-1:0]      bin;
    logic                            in_grid;

    always_comb
    begin
        theta = in_data.origin ? pgim_pkg::THETA_HALF : in_data.th;
        if (cfg.n_angle == '0)
            na = pgim_pkg::CNT_W'(1);
        else if (32'(cfg.n_angle) > ANGLE_BINS_MAX)
            na = pgim_pkg::CNT_W'(ANGLE_BINS_MAX);
        else
            na = cfg.n_angle;
        aprod = 35'(theta) * 35'(na);
        alog  = {in_data.expo, in_data.frac};
        diff  = $signed({1'b0, alog}) - $signed({1'b0, cfg.log2_r_min, 9'b0});

        nval = pgim_pkg::N_W'(diff1_reg * $signed({1'b0, cfg.log_scale}))
             + $signed({1'b0, cfg.radial_offset, 25'b0});

        if (32'(cfg.n_radial) > RADIAL_BINS_MAX)
            nr = pgim_pkg::CNT_W'(RADIAL_BINS_MAX);
        else
            nr = cfg.n_radial;
        bin     = n2_reg[pgim_pkg::N_W-2:pgim_pkg::BIN_SHIFT];
        in_grid = gt2_reg && !n2_reg[pgim_pkg::N_W-1]
               && (bin < pgim_pkg::BIN_W'(nr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            abin1_reg <= aprod[pgim_pkg::FRAC_BITS+pgim_pkg::OUT_BIN_W-1:pgim_pkg::FRAC_BITS];
            diff1_reg <= diff;
            gt1_reg   <= in_data.gt;
        end
        if (rdy2 && v1_reg)
        begin
            abin2_reg <= abin1_reg;
            n2_reg    <= nval;
            gt2_reg   <= gt1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            abin3_reg   <= abin2_reg;
            rbin3_reg   <= in_grid ? bin[pgim_pkg::OUT_BIN_W-1:0] : '0;
            inside3_reg <= in_grid;
        end
    end

    assign res.valid      = v3_reg;
    assign res.angle_bin  = abin3_reg;
    assign res.radial_bin = rbin3_reg;
    assign res.inside_res = inside3_reg;
endmodule

@@ design/polar_grid_index_mapper.sv @@
// ----------------------------------------------------------------------------
// polar_grid_index_mapper
// Maps a Cartesian pixel position to its bin in a mirrored log-radial grid.
// ----------------------------------------------------------------------------
//  channel | dir | transfer content
//  --------+-----+---------------------------------------------
//  pix     | in  | pos_x, pos_y (signed, COORD_BITS)
//  res     | out | radial_bin, angle_bin, inside_res
//  cfg     | in  | index (register number), data (write value)
//
//  One pixel per cycle while res does not stall. Stages: three front stages,
//  24 iteration stages (one angle bit and one log bit each, set by the
//  fraction width), three back stages ending in the output register.
//  Every stage has its own valid bit and loads when it is empty or its
//  successor takes its item, so a stall on res holds and drops nothing.
//  Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "polar_grid_index_mapper_assert.svh"

module polar_grid_index_mapper #(
    parameter int COORD_BITS      = 20,
    parameter int RADIAL_BINS_MAX = 1024,
    parameter int ANGLE_BINS_MAX  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    pgim_pix_if.sink    pix,
    pgim_res_if.source  res,
    pgim_cfg_if.sink    cfg
);
    localparam int STEPS = pgim_pkg::FRAC_BITS;

    // Configuration registers; writes are always taken.
    pgim_pkg::cfg_t cfg_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.r_min_sq      <= '0;
            cfg_reg.log2_r_min    <= '0;
            cfg_reg.log_scale     <= 26'd65536;
            cfg_reg.radial_offset <= 17'd32768;
            cfg_reg.n_radial      <= 11'd1024;
            cfg_reg.n_angle       <= 11'd1024;
        end
        else if (cfg.valid)
        begin
            unique case (pgim_pkg::cfg_reg_t'(cfg.index))
                pgim_pkg::REG_R_MIN_SQ:      cfg_reg.r_min_sq      <= cfg.data;
                pgim_pkg::REG_LOG2_R_MIN:    cfg_reg.log2_r_min    <= cfg.data[20:0];
                pgim_pkg::REG_LOG_SCALE:     cfg_reg.log_scale     <= cfg.data[25:0];
                pgim_pkg::REG_RADIAL_OFFSET: cfg_reg.radial_offset <= cfg.data[16:0];
                pgim_pkg::REG_N_RADIAL:      cfg_reg.n_radial      <= cfg.data[10:0];
                pgim_pkg::REG_N_ANGLE:       cfg_reg.n_angle       <= cfg.data[10:0];
                default:                     ; // unknown index: drop the write
            endcase
        end
    end

    // Pipeline links between the front, the iteration chain and the back.
    logic            st_valid [0:STEPS];
    logic            st_ready [0:STEPS];
    pgim_pkg::iter_t st_data  [0:STEPS];

    pgim_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .r_min_sq  (cfg_reg.r_min_sq),
        .out_valid (st_valid[0]),
        .out_data  (st_data[0]),
        .out_ready (st_ready[0])
    );

    // Advance one angle bit and one log bit per stage.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        pgim_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[k]),
            .in_data   (st_data[k]),
            .in_ready  (st_ready[k]),
            .out_valid (st_valid[k+1]),
            .out_data  (st_data[k+1]),
            .out_ready (st_ready[k+1])
        );
    end

    pgim_back #(
        .RADIAL_BINS_MAX (RADIAL_BINS_MAX),
        .ANGLE_BINS_MAX  (ANGLE_BINS_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (st_valid[STEPS]),
        .in_data  (st_data[STEPS]),
        .in_ready (st_ready[STEPS]),
        .cfg      (cfg_reg),
        .res      (res)
    );

    // An empty output register means every stage can take an item.
    `PGIM_ASSERT_ALWAYS(a_ready_when_drained, res.valid || pix.ready)
    // Outside points carry a zero radial bin.
    `PGIM_ASSERT_IMPLY(a_outside_zero, res.valid && !res.inside_res, res.radial_bin == '0)
    // An inside bin never reaches the radial maximum.
    `PGIM_ASSERT_IMPLY(a_radial_range, res.valid && res.inside_res,
                       32'(res.radial_bin) < RADIAL_BINS_MAX)
    // The angle bin stays below the angular maximum.
    `PGIM_ASSERT_IMPLY(a_angle_range, res.valid, 32'(res.angle_bin) < ANGLE_BINS_MAX)
endmodule
